FILE: rtl/ffva_pkg.sv
package ffva_pkg;

  localparam int MAX_VOICES = 64;
  localparam int POS_W      = 32;
  localparam int LANE_W     = $clog2(MAX_VOICES);
  localparam int CNT_W      = $clog2(MAX_VOICES + 1);
  localparam int IDX_OUT_W  = 6;
  localparam int CNT_OUT_W  = 7;

  typedef struct packed {
    logic new_track;
    logic grow;
    logic force_lane;
    logic commit;
  } ffva_ctrl_t;

endpackage

FILE: rtl/ffva_cell.sv
module ffva_cell
  import ffva_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  ffva_ctrl_t       ctrl,
  input  logic [POS_W-1:0] start_pos,
  input  logic [POS_W-1:0] end_pos,
  input  logic             force_sel,
  input  logic             found_in,
  input  logic             prev_open_in,
  output logic             found_out,
  output logic             open_out,
  output logic             wr
);

  logic             open;
  logic [POS_W-1:0] lane_end;
  logic             open_eff;
  logic             free;
  logic             first_closed;

  assign open_eff     = open & ~ctrl.new_track;
  assign free         = open_eff & (lane_end <= start_pos);
  assign found_out    = found_in | free;
  assign open_out     = open_eff;
  assign first_closed = ~open_eff & prev_open_in;
  assign wr = (free & ~found_in) | (first_closed & ctrl.grow) | (force_sel & ctrl.force_lane);

  always_ff @(posedge clk) begin
    if (rst) begin
      open <= 1'b0;
    end else if (ctrl.commit) begin
      open <= open_eff | wr;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit && wr) begin
      lane_end <= end_pos;
    end
  end

endmodule

FILE: rtl/first_fit_voice_allocator_unit.sv
// channel | valid       | stall       | payload
// note    | note_valid  | note_stall  | new_track, start_pos, end_pos
// voice   | voice_valid | voice_stall | voice_index, voice_count, overflow
//
// a note is registered, then its work cycle does the compare across the
// lane cells, the priority pick along the cell chain and the lane write-back
// a note is taken while the previous result still waits in the output register
// while that result is stalled the work cycle holds and note_stall stays high
// synchronous reset closes every lane and clears the count; no clearing pass
module first_fit_voice_allocator_unit
  import ffva_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 note_valid,
  output logic                 note_stall,
  input  logic                 new_track,
  input  logic [POS_W-1:0]     start_pos,
  input  logic [POS_W-1:0]     end_pos,
  output logic                 voice_valid,
  input  logic                 voice_stall,
  output logic [IDX_OUT_W-1:0] voice_index,
  output logic [CNT_OUT_W-1:0] voice_count,
  output logic                 overflow
);

  logic              busy;
  logic              nt_r;
  logic [POS_W-1:0]  start_r;
  logic [POS_W-1:0]  end_r;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_eff;
  logic [CNT_W-1:0]  count_next;
  logic              full;
  logic              no_free;
  logic              work;
  logic              accept;
  ffva_ctrl_t        ctrl;
  logic [MAX_VOICES:0]   found;
  logic [MAX_VOICES:0]   open_chain;
  logic [MAX_VOICES-1:0] wr;
  logic [LANE_W-1:0]     enc;

  assign note_stall = busy;
  assign accept     = note_valid & ~busy;
  assign work       = busy & (~voice_valid | ~voice_stall);

  assign count_eff  = nt_r ? '0 : count;
  assign full       = (count_eff == CNT_W'(MAX_VOICES));
  assign no_free    = ~found[MAX_VOICES];
  assign count_next = count_eff + CNT_W'(no_free & ~full);

  always_comb begin
    ctrl.new_track  = nt_r;
    ctrl.grow       = no_free & ~full;
    ctrl.force_lane = no_free & full;
    ctrl.commit     = work;
  end

  assign found[0]      = 1'b0;
  assign open_chain[0] = 1'b1;

  for (genvar g = 0; g < MAX_VOICES; g++) begin : g_cell
    ffva_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .start_pos    (start_r),
      .end_pos      (end_r),
      .force_sel    (g == 0),
      .found_in     (found[g]),
      .prev_open_in (open_chain[g]),
      .found_out    (found[g+1]),
      .open_out     (open_chain[g+1]),
      .wr           (wr[g])
    );
  end

  always_comb begin
    enc = '0;
    for (int i = 0; i < MAX_VOICES; i++) begin
      if (wr[i]) begin
        enc = enc | LANE_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      nt_r    <= new_track;
      start_r <= start_pos;
      end_r   <= end_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      count       <= '0;
      voice_valid <= 1'b0;
    end else begin
      if (work) begin
        busy        <= 1'b0;
        count       <= count_next;
        voice_valid <= 1'b1;
      end else begin
        if (accept) begin
          busy <= 1'b1;
        end
        if (voice_valid && !voice_stall) begin
          voice_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      voice_index <= IDX_OUT_W'(enc);
      voice_count <= (count_next == '0) ? CNT_OUT_W'(1) : CNT_OUT_W'(count_next);
      overflow    <= ctrl.force_lane;
    end
  end

`ifndef SYNTH
  a_one_lane_written: assert property (@(posedge clk) disable iff (rst)
    work |-> $onehot(wr))
    else $error("work cycle must write exactly one lane");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_VOICES))
    else $error("lane count above lane total");

  a_overflow_lane0: assert property (@(posedge clk) disable iff (rst)
    voice_valid && overflow |-> voice_index == '0)
    else $error("overflow must force lane 0");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    busy && voice_valid && voice_stall |=> busy)
    else $error("note finished while result slot was stalled");
`endif

endmodule

FILE: tb/sv/first_fit_voice_allocator_unit_tb.sv
`timescale 1ns / 1ps

module first_fit_voice_allocator_unit_tb;
  import ffva_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 400;

  typedef struct {
    bit             new_track;
    bit [POS_W-1:0] start_pos;
    bit [POS_W-1:0] end_pos;
  } note_t;

  typedef struct {
    bit [IDX_OUT_W-1:0] lane;
    bit [CNT_OUT_W-1:0] count;
    bit                 ovf;
  } voice_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 note_valid = 1'b0;
  logic                 note_stall;
  logic                 new_track = 1'b0;
  logic [POS_W-1:0]     start_pos = '0;
  logic [POS_W-1:0]     end_pos = '0;
  logic                 voice_valid;
  logic                 voice_stall = 1'b0;
  logic [IDX_OUT_W-1:0] voice_index;
  logic [CNT_OUT_W-1:0] voice_count;
  logic                 overflow;

  first_fit_voice_allocator_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .note_valid  (note_valid),
    .note_stall  (note_stall),
    .new_track   (new_track),
    .start_pos   (start_pos),
    .end_pos     (end_pos),
    .voice_valid (voice_valid),
    .voice_stall (voice_stall),
    .voice_index (voice_index),
    .voice_count (voice_count),
    .overflow    (overflow)
  );

  note_t          pending_notes[$];
  voice_t         expected_voices[$];
  note_t          cur_note;
  bit [POS_W-1:0] lane_end[MAX_VOICES];
  int             lanes_open = 0;
  int             notes_accepted = 0;
  int             burst_left = 0;
  int             gap_left = 0;
  int             mismatch_count = 0;
  int             stray_count = 0;
  int             cycle_count = 0;
  int             hold_left = 0;
  bit             hold_done = 1'b0;
  int             rx_mode = 0;
  int             rx_mode_left = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // first-fit lane choice, updates the lane ends and the open count
  function automatic voice_t place_note(note_t n);
    voice_t v;
    bit     found;
    int     lane;
    int     count;
    found = 1'b0;
    lane = 0;
    v.ovf = 1'b0;
    if (n.new_track) lanes_open = 0;
    for (int i = 0; i < lanes_open; i++) begin
      if (!found && lane_end[i] <= n.start_pos) begin
        found = 1'b1;
        lane = i;
      end
    end
    if (!found) begin
      if (lanes_open < MAX_VOICES) begin
        lane = lanes_open;
        lanes_open++;
      end else begin
        lane = 0;
        v.ovf = 1'b1;
      end
    end
    lane_end[lane] = n.end_pos;
    count = (lanes_open < 1) ? 1 : lanes_open;
    v.lane = lane[IDX_OUT_W-1:0];
    v.count = count[CNT_OUT_W-1:0];
    return v;
  endfunction

  function automatic note_t mk_note(bit nt, bit [POS_W-1:0] s, bit [POS_W-1:0] e);
    note_t n;
    n.new_track = nt;
    n.start_pos = s;
    n.end_pos = e;
    return n;
  endfunction

  task automatic add_track(int len, bit dense, bit fresh);
    bit [POS_W-1:0] pos;
    bit [POS_W-1:0] dur;
    pos = $urandom;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        // noise: unordered positions, random track flag
        pending_notes.push_back(mk_note($urandom_range(0, 7) == 0, $urandom, $urandom));
      end else begin
        pos = pos + (dense ? $urandom_range(0, 3) : $urandom_range(0, 256));
        dur = dense ? $urandom_range(32'h1000, 32'hf_ffff) : $urandom_range(0, 600);
        pending_notes.push_back(mk_note(fresh && k == 0, pos, pos + dur));
      end
    end
  endtask

  // stimulus and end of run
  initial begin
    pending_notes.push_back(mk_note(1'b1, 32'h0000_0000, 32'h0000_0100));
    pending_notes.push_back(mk_note(1'b0, 32'h0000_0000, 32'h0000_0080));
    pending_notes.push_back(mk_note(1'b0, 32'h0000_0080, 32'h0000_0200));
    pending_notes.push_back(mk_note(1'b0, 32'h0000_0100, 32'h0000_0100));
    pending_notes.push_back(mk_note(1'b0, 32'h0000_0300, 32'h0000_0010));
    pending_notes.push_back(mk_note(1'b0, 32'h0000_0300, 32'hffff_ffff));
    pending_notes.push_back(mk_note(1'b0, 32'h0000_0400, 32'hffff_ffff));
    pending_notes.push_back(mk_note(1'b0, 32'h0000_0500, 32'h0000_0600));
    pending_notes.push_back(mk_note(1'b0, 32'hffff_ffff, 32'hffff_ffff));
    pending_notes.push_back(mk_note(1'b1, 32'hffff_ffff, 32'h0000_0000));
    pending_notes.push_back(mk_note(1'b0, 32'h0000_0000, 32'h0000_0000));
    pending_notes.push_back(mk_note(1'b0, 32'h0000_0000, 32'h0000_0001));
    pending_notes.push_back(mk_note(1'b1, 32'h1234_5678, 32'hedcb_a987));
    pending_notes.push_back(mk_note(1'b0, 32'h5555_5555, 32'haaaa_aaaa));
    pending_notes.push_back(mk_note(1'b0, 32'haaaa_aaaa, 32'h5555_5555));
    pending_notes.push_back(mk_note(1'b1, 32'h0001_0000, 32'h0002_0000));
    pending_notes.push_back(mk_note(1'b0, 32'h0001_8000, 32'h0002_8000));
    pending_notes.push_back(mk_note(1'b0, 32'h0002_0000, 32'h0003_0000));
    // dense track long enough to run out of lanes
    add_track(90, 1'b1, 1'b1);
    while (pending_notes.size() < 2000) begin
      add_track($urandom_range(1, 120), $urandom_range(0, 3) == 0, $urandom_range(0, 7) != 0);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_notes.size() != 0 || note_valid) @(posedge clk);
    while (expected_voices.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && stray_count == 0 && expected_voices.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // driver: bursts of transactions with random gaps
  always @(posedge clk) begin
    if (rst) begin
      note_valid <= 1'b0;
    end else begin
      bit take_next;
      take_next = 1'b0;
      if (note_valid && !note_stall) begin
        expected_voices.push_back(place_note(cur_note));
        notes_accepted++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          if (gap_left == 0) take_next = 1'b1;
          else note_valid <= 1'b0;
        end else begin
          take_next = 1'b1;
        end
      end else if (!note_valid) begin
        if (gap_left > 0) gap_left--;
        else take_next = 1'b1;
      end
      if (take_next) begin
        if (pending_notes.size() != 0) begin
          cur_note = pending_notes.pop_front();
          note_valid <= 1'b1;
          new_track <= cur_note.new_track;
          start_pos <= cur_note.start_pos;
          end_pos <= cur_note.end_pos;
        end else begin
          note_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && notes_accepted >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    bit stall_bit;
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(20, 200);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      0: stall_bit = 1'b0;
      1: stall_bit = $urandom_range(0, 1);
      2: stall_bit = ($urandom_range(0, 9) == 0);
      default: stall_bit = cycle_count[0];
    endcase
    voice_stall <= rst ? 1'b0 : (stall_bit || hold_left != 0);
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && voice_valid && !voice_stall) begin
      if (expected_voices.size() == 0) begin
        stray_count++;
        if (stray_count + mismatch_count <= 10)
          $display("unexpected transaction: lane %0d count %0d overflow %0d",
                   voice_index, voice_count, overflow);
      end else begin
        voice_t exp_v;
        exp_v = expected_voices.pop_front();
        if (voice_index !== exp_v.lane || voice_count !== exp_v.count ||
            overflow !== exp_v.ovf) begin
          mismatch_count++;
          if (stray_count + mismatch_count <= 10)
            $display("mismatch: expected lane %0d count %0d overflow %0d, got %0d %0d %0d",
                     exp_v.lane, exp_v.count, exp_v.ovf, voice_index, voice_count, overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
